// File: rtl/core/backlight_pulse_step_dimmer_unit_macros.svh
// assertion macros shared by the dimmer rtl
`ifndef BACKLIGHT_PULSE_STEP_DIMMER_UNIT_MACROS_SVH
`define BACKLIGHT_PULSE_STEP_DIMMER_UNIT_MACROS_SVH

// same-cycle implication, checked on the rising clock edge outside reset
`define BPSD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked on the rising clock edge outside reset
`define BPSD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/bpsd_pkg.sv
// constants, tables and register map of the backlight step dimmer
`timescale 1ns / 1ps
`default_nettype none
package bpsd_pkg;

  localparam int LVL_W  = 8;
  localparam int STEP_W = 6;
  localparam int DSTEP_W = 5;
  localparam int HOLD_W = 12;
  localparam int ACT_W  = 2;

  localparam int STEP_COUNT_DEF    = 32;
  localparam int TABLE_ENTRIES_DEF = 21;
  localparam int TAB_DEPTH         = 21;
  localparam int TAB_IDX_W         = $clog2(TAB_DEPTH);

  localparam logic [LVL_W-1:0]   MIN_BRIGHTNESS_RST = 8'd30;
  localparam logic [DSTEP_W-1:0] DIMMING_STEP_RST   = 5'd29;

  // register map, byte address is 4 * index
  localparam logic REG_MIN_BRIGHTNESS = 1'b0;
  localparam logic REG_DIMMING_STEP   = 1'b1;

  localparam logic [ACT_W-1:0] ACT_LOW   = 2'd0;
  localparam logic [ACT_W-1:0] ACT_HIGH  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_PULSE = 2'd2;
  localparam logic [ACT_W-1:0] ACT_WAIT  = 2'd3;

  localparam logic [HOLD_W-1:0] HOLD_OFF_US   = 12'd3000;
  localparam logic [HOLD_W-1:0] HOLD_PULSE_US = 12'd3;
  localparam logic [HOLD_W-1:0] HOLD_WAIT_US  = 12'd1000;

  // descending level thresholds and the chip step of each interval
  localparam logic [LVL_W-1:0] LVL_TAB [TAB_DEPTH] = '{
    8'd255, 8'd240, 8'd230, 8'd220, 8'd210, 8'd200, 8'd190, 8'd180, 8'd170, 8'd160,
    8'd150, 8'd141, 8'd125, 8'd110, 8'd95, 8'd80, 8'd65, 8'd50, 8'd30, 8'd20, 8'd0
  };
  localparam logic [DSTEP_W-1:0] STEP_TAB [TAB_DEPTH] = '{
    5'd9, 5'd10, 5'd11, 5'd12, 5'd13, 5'd14, 5'd15, 5'd16, 5'd17, 5'd18,
    5'd19, 5'd20, 5'd21, 5'd22, 5'd23, 5'd24, 5'd25, 5'd26, 5'd27, 5'd29, 5'd30
  };

endpackage
`default_nettype wire

// File: rtl/core/backlight_pulse_step_dimmer_unit.sv
// Backlight step dimmer: one brightness request becomes a run of line commands
// (drive low, drive high, low/high pulse, wait) that walks the backlight chip
// from its tracked step to the target step. One request is handled at a time
// by a small sequencer around one shared 8-bit subtract/compare unit; in_tready
// is high only while idle. A request passes through the target check, a scan of
// at most TABLE_ENTRIES table entries, the reduction of both steps by repeated
// subtraction of STEP_COUNT, the pulse count and then the emission of its
// commands (at most STEP_COUNT+2), one per cycle while the output side takes
// them. The result register lets the last command wait on out_tready while the
// next request is already taken. Configuration is an APB-style port with
// min_brightness at 0x0 and dimming_step at 0x4; no clearing pass after reset.
`timescale 1ns / 1ps
`default_nettype none
`include "backlight_pulse_step_dimmer_unit_macros.svh"
module backlight_pulse_step_dimmer_unit #(
  parameter int STEP_COUNT    = bpsd_pkg::STEP_COUNT_DEF,
  parameter int TABLE_ENTRIES = bpsd_pkg::TABLE_ENTRIES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // request channel
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // [7:0] brightness_level, [8] pin_was_high
  // command channel
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,  // [1:0] action, [13:2] hold_us
  output logic             out_tlast,
  // configuration
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  localparam int LVL_W   = bpsd_pkg::LVL_W;
  localparam int STEP_W  = bpsd_pkg::STEP_W;
  localparam int DSTEP_W = bpsd_pkg::DSTEP_W;
  localparam int HOLD_W  = bpsd_pkg::HOLD_W;
  localparam int ACT_W   = bpsd_pkg::ACT_W;
  localparam int IDX_W   = bpsd_pkg::TAB_IDX_W;
  localparam int ALU_W   = LVL_W;
  localparam int SCAN_N  = (TABLE_ENTRIES < bpsd_pkg::TAB_DEPTH) ?
                           TABLE_ENTRIES : bpsd_pkg::TAB_DEPTH;

  localparam logic [ALU_W-1:0]  SC_A   = ALU_W'(STEP_COUNT);
  localparam logic [STEP_W-1:0] SC_S   = STEP_W'(STEP_COUNT);
  localparam logic [IDX_W:0]    SCAN_L = (IDX_W+1)'(SCAN_N);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_TGT  = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_DEC  = 3'd3;
  localparam logic [2:0] S_MODT = 3'd4;
  localparam logic [2:0] S_MODC = 3'd5;
  localparam logic [2:0] S_PCNT = 3'd6;
  localparam logic [2:0] S_EMIT = 3'd7;

  logic [2:0]         state_r, state_nxt;
  logic [LVL_W-1:0]   min_bright_r;
  logic [DSTEP_W-1:0] dim_step_r;
  logic               known_r, known_nxt;
  logic [STEP_W-1:0]  cur_r, cur_nxt;
  logic [LVL_W-1:0]   level_r, level_nxt;
  logic               pin_r, pin_nxt;
  logic [STEP_W-1:0]  t_r, t_nxt;
  logic [STEP_W-1:0]  tm_r, tm_nxt;
  logic [STEP_W-1:0]  cm_r, cm_nxt;
  logic [STEP_W-1:0]  p_r, p_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  logic               need_low_r, need_low_nxt;
  logic               need_high_r, need_high_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic [ACT_W-1:0]   out_act_r, out_act_nxt;
  logic [HOLD_W-1:0]  out_hold_r, out_hold_nxt;
  logic               out_last_r, out_last_nxt;

  // shared subtract/compare unit
  logic [ALU_W-1:0] alu_a, alu_b;
  logic [ALU_W:0]   alu_diff;
  logic             alu_borrow;

  logic             in_acc, cfg_wr, slot_free, final_emit;
  logic [IDX_W:0]   idx_next;
  logic             scan_end, scan_hit;
  logic [STEP_W-1:0] cur_eff;

  assign in_acc     = in_tvalid && in_tready;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign slot_free  = !out_valid_r || out_tready;
  assign idx_next   = {1'b0, idx_r} + 1'b1;
  assign scan_end   = idx_next >= SCAN_L;
  assign scan_hit   = !scan_end &&
                      (level_r <= bpsd_pkg::LVL_TAB[idx_r]) &&
                      (level_r > bpsd_pkg::LVL_TAB[idx_next[IDX_W-1:0]]);
  assign cur_eff    = known_r ? cur_r : '0;
  assign final_emit = (state_r == S_EMIT) && slot_free && !need_low_r &&
                      !need_high_r && (p_r == '0);

  always_comb begin
    alu_a = '0;
    alu_b = '0;
    case (state_r)
      S_TGT: begin
        alu_a = level_r;
        alu_b = min_bright_r;
      end
      S_MODT: begin
        alu_a = ALU_W'(tm_r);
        alu_b = SC_A;
      end
      S_MODC: begin
        alu_a = ALU_W'(cm_r);
        alu_b = SC_A;
      end
      S_PCNT: begin
        alu_a = ALU_W'(tm_r);
        alu_b = ALU_W'(cm_r);
      end
      S_EMIT: begin
        alu_a = ALU_W'(p_r);
        alu_b = ALU_W'(1);
      end
      default: begin
        alu_a = '0;
        alu_b = '0;
      end
    endcase
  end

  assign alu_diff   = {1'b0, alu_a} - {1'b0, alu_b};
  assign alu_borrow = alu_diff[ALU_W];

  always_comb begin
    state_nxt     = state_r;
    known_nxt     = known_r;
    cur_nxt       = cur_r;
    level_nxt     = level_r;
    pin_nxt       = pin_r;
    t_nxt         = t_r;
    tm_nxt        = tm_r;
    cm_nxt        = cm_r;
    p_nxt         = p_r;
    idx_nxt       = idx_r;
    need_low_nxt  = need_low_r;
    need_high_nxt = need_high_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_act_nxt   = out_act_r;
    out_hold_nxt  = out_hold_r;
    out_last_nxt  = out_last_r;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          level_nxt = in_tdata[LVL_W-1:0];
          pin_nxt   = in_tdata[LVL_W];
          state_nxt = S_TGT;
        end
      end
      S_TGT: begin
        idx_nxt = '0;
        if (level_r == '0) begin
          t_nxt     = '0;
          state_nxt = S_DEC;
        end else if (alu_borrow) begin
          // dim request below the minimum level
          t_nxt     = STEP_W'(dim_step_r);
          state_nxt = S_DEC;
        end else begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_end) begin
          t_nxt     = '0;
          state_nxt = S_DEC;
        end else if (scan_hit) begin
          t_nxt     = STEP_W'(bpsd_pkg::STEP_TAB[idx_r]);
          state_nxt = S_DEC;
        end else begin
          idx_nxt = idx_next[IDX_W-1:0];
        end
      end
      S_DEC: begin
        need_low_nxt  = 1'b0;
        need_high_nxt = 1'b0;
        p_nxt         = '0;
        if (known_r && (t_r == cur_r)) begin
          state_nxt = S_EMIT;
        end else if (t_r == '0) begin
          need_low_nxt = 1'b1;
          state_nxt    = S_EMIT;
        end else begin
          need_low_nxt  = !known_r && pin_r;
          need_high_nxt = (cur_eff == '0);
          tm_nxt        = t_r;
          // after the turn-on high level the chip sits at step one
          cm_nxt        = (cur_eff == '0) ? STEP_W'(1) : cur_eff;
          state_nxt     = S_MODT;
        end
      end
      S_MODT: begin
        if (alu_borrow) begin
          state_nxt = S_MODC;
        end else begin
          tm_nxt = alu_diff[STEP_W-1:0];
        end
      end
      S_MODC: begin
        if (alu_borrow) begin
          state_nxt = S_PCNT;
        end else begin
          cm_nxt = alu_diff[STEP_W-1:0];
        end
      end
      S_PCNT: begin
        // wrap the step difference into one chip cycle
        p_nxt     = alu_borrow ? (alu_diff[STEP_W-1:0] + SC_S) : alu_diff[STEP_W-1:0];
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_last_nxt  = 1'b0;
          if (need_low_r) begin
            need_low_nxt = 1'b0;
            out_act_nxt  = bpsd_pkg::ACT_LOW;
            out_hold_nxt = bpsd_pkg::HOLD_OFF_US;
          end else if (need_high_r) begin
            need_high_nxt = 1'b0;
            out_act_nxt   = bpsd_pkg::ACT_HIGH;
            out_hold_nxt  = bpsd_pkg::HOLD_PULSE_US;
          end else if (p_r != '0) begin
            p_nxt        = alu_diff[STEP_W-1:0];
            out_act_nxt  = bpsd_pkg::ACT_PULSE;
            out_hold_nxt = bpsd_pkg::HOLD_PULSE_US;
          end else begin
            out_act_nxt  = bpsd_pkg::ACT_WAIT;
            out_hold_nxt = bpsd_pkg::HOLD_WAIT_US;
            out_last_nxt = 1'b1;
            known_nxt    = 1'b1;
            cur_nxt      = t_r;
            state_nxt    = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      known_r      <= 1'b0;
      cur_r        <= '0;
      out_valid_r  <= 1'b0;
      need_low_r   <= 1'b0;
      need_high_r  <= 1'b0;
      p_r          <= '0;
      idx_r        <= '0;
      min_bright_r <= bpsd_pkg::MIN_BRIGHTNESS_RST;
      dim_step_r   <= bpsd_pkg::DIMMING_STEP_RST;
    end else begin
      state_r     <= state_nxt;
      known_r     <= known_nxt;
      cur_r       <= cur_nxt;
      out_valid_r <= out_valid_nxt;
      need_low_r  <= need_low_nxt;
      need_high_r <= need_high_nxt;
      p_r         <= p_nxt;
      idx_r       <= idx_nxt;
      if (cfg_wr) begin
        if (cfg_paddr[2] == bpsd_pkg::REG_MIN_BRIGHTNESS) begin
          min_bright_r <= cfg_pwdata[LVL_W-1:0];
        end else begin
          dim_step_r <= cfg_pwdata[DSTEP_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    level_r    <= level_nxt;
    pin_r      <= pin_nxt;
    t_r        <= t_nxt;
    tm_r       <= tm_nxt;
    cm_r       <= cm_nxt;
    out_act_r  <= out_act_nxt;
    out_hold_r <= out_hold_nxt;
    out_last_r <= out_last_nxt;
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_hold_r, out_act_r};
  assign out_tlast  = out_last_r;
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == bpsd_pkg::REG_DIMMING_STEP) ?
                      32'(dim_step_r) : 32'(min_bright_r);

  `BPSD_ASSERT_NEXT(a_accept_starts, in_acc, state_r == S_TGT,
                    "request accepted but sequencer did not start")
  `BPSD_ASSERT_NOW(a_last_is_wait, out_valid_r && out_last_r,
                   out_act_r == bpsd_pkg::ACT_WAIT, "last command is not the final wait")
  `BPSD_ASSERT_NOW(a_pulse_hold, out_valid_r && (out_act_r == bpsd_pkg::ACT_PULSE),
                   out_hold_r == bpsd_pkg::HOLD_PULSE_US && !out_last_r,
                   "pulse command with wrong hold or last")
  `BPSD_ASSERT_NEXT(a_commit_step, final_emit,
                    known_r && (cur_r == $past(t_r)) && in_tready,
                    "tracked step not committed at end of request")
  `BPSD_ASSERT_NOW(a_pulse_range, state_r == S_EMIT, p_r < SC_S || STEP_COUNT == 64,
                   "pulse count beyond one chip cycle")

endmodule
`default_nettype wire

// File: verif/bpsd_cmd_checker.sv
// command checker for the backlight step dimmer: predicts each request's line commands
`timescale 1ns / 1ps
module bpsd_cmd_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [15:0] in_tdata,    // [7:0] brightness_level, [8] pin_was_high
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [15:0] out_tdata,   // [1:0] action, [13:2] hold_us
  input  logic        out_tlast,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  input  logic        cfg_pready,
  output int          mismatches,
  output int          pending
);

  localparam int STEPS  = 32;
  localparam int BOUNDS = 21;

  localparam logic [11:0] OFF_US   = 12'd3000;
  localparam logic [11:0] PULSE_US = 12'd3;
  localparam logic [11:0] WAIT_US  = 12'd1000;

  // level intervals (upper bound inclusive, next bound exclusive) and their chip step
  localparam logic [7:0] LEVEL_BOUND [BOUNDS] = '{
    8'd255, 8'd240, 8'd230, 8'd220, 8'd210, 8'd200, 8'd190, 8'd180, 8'd170, 8'd160,
    8'd150, 8'd141, 8'd125, 8'd110, 8'd95, 8'd80, 8'd65, 8'd50, 8'd30, 8'd20, 8'd0
  };
  localparam logic [5:0] BOUND_STEP [BOUNDS] = '{
    6'd9, 6'd10, 6'd11, 6'd12, 6'd13, 6'd14, 6'd15, 6'd16, 6'd17, 6'd18,
    6'd19, 6'd20, 6'd21, 6'd22, 6'd23, 6'd24, 6'd25, 6'd26, 6'd27, 6'd29, 6'd30
  };

  typedef struct packed {
    logic [bpsd_pkg::ACT_W-1:0]  act;
    logic [bpsd_pkg::HOLD_W-1:0] hold;
    logic                        last;
  } line_cmd_t;

  logic [7:0] min_br;
  logic [4:0] dim_step;
  logic       step_known;
  logic [5:0] chip_step;
  line_cmd_t  cmd_q[$];

  function automatic void add_cmd(input logic [bpsd_pkg::ACT_W-1:0] act,
                                  input logic [11:0] hold, input logic last);
    line_cmd_t c;
    c.act  = act;
    c.hold = hold;
    c.last = last;
    cmd_q.push_back(c);
  endfunction

  function automatic logic [5:0] target_step(input logic [7:0] level);
    if (level == 8'd0) return 6'd0;
    if (level < min_br) return {1'b0, dim_step};
    for (int i = 0; i < BOUNDS - 1; i++)
      if (level <= LEVEL_BOUND[i] && level > LEVEL_BOUND[i+1]) return BOUND_STEP[i];
    return 6'd0;
  endfunction

  // commands that walk the chip from its tracked step to the requested one
  function automatic void plan_request(input logic [7:0] level, input logic pin_high);
    logic [5:0] tgt;
    logic [5:0] start_step;
    int         pulses;
    tgt = target_step(level);
    if (!step_known || tgt != chip_step) begin
      if (tgt == 6'd0) begin
        add_cmd(bpsd_pkg::ACT_LOW, OFF_US, 1'b0);
      end else begin
        start_step = step_known ? chip_step : 6'd0;
        if (!step_known && pin_high) add_cmd(bpsd_pkg::ACT_LOW, OFF_US, 1'b0);
        if (start_step == 6'd0) begin
          add_cmd(bpsd_pkg::ACT_HIGH, PULSE_US, 1'b0);
          start_step = 6'd1;
        end
        pulses = ((tgt % STEPS) + STEPS - (start_step % STEPS)) % STEPS;
        repeat (pulses) add_cmd(bpsd_pkg::ACT_PULSE, PULSE_US, 1'b0);
      end
      step_known = 1'b1;
      chip_step  = tgt;
    end
    add_cmd(bpsd_pkg::ACT_WAIT, WAIT_US, 1'b1);
  endfunction

  always @(posedge clk) begin
    line_cmd_t got;
    line_cmd_t want;
    if (!rst_n) begin
      min_br     = 8'd30;
      dim_step   = 5'd29;
      step_known = 1'b0;
      chip_step  = 6'd0;
      cmd_q.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (cfg_paddr[2])
          bpsd_pkg::REG_MIN_BRIGHTNESS: min_br   = cfg_pwdata[7:0];
          bpsd_pkg::REG_DIMMING_STEP:   dim_step = cfg_pwdata[4:0];
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        got.act  = out_tdata[1:0];
        got.hold = out_tdata[13:2];
        got.last = out_tlast;
        if (cmd_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected command act=%0d hold=%0d last=%0b",
                     $realtime, got.act, got.hold, got.last);
        end else begin
          want = cmd_q.pop_front();
          if (got.act !== want.act || got.hold !== want.hold || got.last !== want.last) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"%0t: command mismatch: expected act=%0d hold=%0d last=%0b,",
                        " got act=%0d hold=%0d last=%0b"},
                       $realtime, want.act, want.hold, want.last,
                       got.act, got.hold, got.last);
          end
        end
      end
      // outputs first so a command leaving this edge never meets a request taken now
      if (in_tvalid && in_tready) plan_request(in_tdata[7:0], in_tdata[8]);
    end
    pending = cmd_q.size();
  end

endmodule

// File: verif/tb_backlight_pulse_step_dimmer_unit.sv
// testbench top for the backlight step dimmer: stimulus, idling and the verdict
`timescale 1ns / 1ps
module tb_backlight_pulse_step_dimmer_unit;

  localparam int          LIMIT_CYCLES    = 4000000;
  localparam int          HOLD_OFF_CYCLES = 400;
  localparam int          PHASES          = 7;
  localparam int          PHASE_ITEMS     = 45;
  localparam logic [2:0]  ADDR_MIN_BR     = {bpsd_pkg::REG_MIN_BRIGHTNESS, 2'b00};
  localparam logic [2:0]  ADDR_DIM_STEP   = {bpsd_pkg::REG_DIMMING_STEP, 2'b00};

  // zero settings on both registers are included on purpose
  localparam logic [7:0] PHASE_MIN [PHASES] = '{8'd1, 8'd255, 8'd0, 8'd128, 8'd0, 8'd200, 8'd17};
  localparam logic [4:0] PHASE_DIM [PHASES] = '{5'd1, 5'd31, 5'd0, 5'd16, 5'd31, 5'd0, 5'd5};

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = 16'd0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic        out_tlast;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = 3'd0;
  logic [31:0] cfg_pwdata = 32'd0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  int          mismatches;
  int          pending;
  int unsigned cycles = 0;
  bit          no_idle = 1'b0;
  bit          hold_off_go = 1'b0;
  logic [7:0]  cur_min = 8'd30;
  logic [7:0]  prev_level = 8'd0;

  always #10 clk = ~clk;

  backlight_pulse_step_dimmer_unit u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  bpsd_cmd_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_pready (cfg_pready),
    .mismatches (mismatches),
    .pending    (pending)
  );

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 60);
  endfunction

  function automatic logic [7:0] pick_level();
    int r;
    r = $urandom_range(0, 99);
    if (r < 12) return 8'd0;
    if (r < 22) return prev_level;
    if (r < 50)
      return bpsd_pkg::LVL_TAB[$urandom_range(0, bpsd_pkg::TAB_DEPTH - 1)] +
             8'($urandom_range(0, 2)) - 8'd1;
    if (r < 60) return cur_min + 8'($urandom_range(0, 2)) - 8'd1;
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic send_req(input logic [7:0] level, input logic pin_high);
    int gap;
    in_tdata  <= {7'd0, pin_high, level};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    prev_level = level;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [2:0] addr, input logic [31:0] data);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // receiver: random stalls, one long hold-off so the block backs up into its input
  initial begin
    int gap;
    bit hold_done;
    hold_done = 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      if (hold_off_go && !hold_done) begin
        hold_done = 1'b1;
        out_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end
      gap = pick_gap();
      if (gap == 0) begin
        out_tready <= 1'b1;
        @(posedge clk);
      end else begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT_CYCLES) begin
      $display("** backlight_pulse_step_dimmer_unit: FAILED **");
      $finish;
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: first request with the line already high, repeats, wraps, off, dim
    send_req(8'd255, 1'b1);
    send_req(8'd241, 1'b0);
    send_req(8'd240, 1'b0);
    send_req(8'd0,   1'b0);
    send_req(8'd0,   1'b1);
    send_req(8'd1,   1'b1);
    send_req(8'd29,  1'b0);
    send_req(8'd30,  1'b1);
    send_req(8'd50,  1'b0);
    send_req(8'd51,  1'b0);
    send_req(8'd20,  1'b0);
    send_req(8'd141, 1'b1);
    send_req(8'd142, 1'b0);
    send_req(8'd125, 1'b0);
    send_req(8'd128, 1'b1);
    send_req(8'd200, 1'b0);
    send_req(8'd170, 1'b1);
    send_req(8'd85,  1'b1);
    send_req(8'd0,   1'b0);
    send_req(8'd64,  1'b0);
    send_req(8'd255, 1'b0);

    for (int p = 0; p < PHASES; p++) begin
      wait_idle();
      cfg_write(ADDR_MIN_BR, {16'($urandom_range(0, 16'hffff)),
                              8'($urandom_range(0, 255)), PHASE_MIN[p]});
      cfg_write(ADDR_DIM_STEP, {16'($urandom_range(0, 16'hffff)),
                                11'($urandom_range(0, 2047)), PHASE_DIM[p]});
      cur_min = PHASE_MIN[p];
      no_idle = (p == 3);
      if (p == 1) hold_off_go = 1'b1;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        // sender stops until the block has drained
        if (p == 4 && i == PHASE_ITEMS / 2) wait_idle();
        send_req(pick_level(), 1'($urandom_range(0, 1)));
      end
    end

    wait_idle();
    repeat (80) @(posedge clk);
    if (mismatches == 0 && pending == 0)
      $display("** backlight_pulse_step_dimmer_unit: PASSED **");
    else
      $display("** backlight_pulse_step_dimmer_unit: FAILED **");
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl/core
rtl/core/bpsd_pkg.sv
rtl/core/backlight_pulse_step_dimmer_unit.sv
verif/bpsd_cmd_checker.sv
verif/tb_backlight_pulse_step_dimmer_unit.sv
